>>> hw/rtl/afg_pkg.sv
// Shared types and constants of the audio frame queue with prefill gate.
package afg_pkg;

  localparam int SAMPLE_W     = 32;
  localparam int FREE_W       = 14;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int PREFILL_W    = 13;
  localparam int CHAN_W       = 2;
  localparam int QUEUE_DEPTH  = 2;

  localparam int FIFO_FRAMES_DEF  = 8192;
  localparam int MAX_CHANNELS_DEF = 2;
  localparam int SAMPLE_BITS_DEF  = 32;

  localparam logic [PREFILL_W-1:0] PREFILL_RST = PREFILL_W'(2048);
  localparam logic [CHAN_W-1:0]    CHAN_RST    = CHAN_W'(1);
  localparam logic [CHAN_W-1:0]    CHAN_STEREO = CHAN_W'(2);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFILL  = 2'd2;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } afg_op_e;

  typedef struct packed {
    afg_op_e             op;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic                qstart;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  typedef struct packed {
    logic                 enable;
    logic [CHAN_W-1:0]    channels;
    logic [PREFILL_W-1:0] prefill;
  } cfg_t;

endpackage

>>> hw/rtl/afg_ifs.sv
// Channel interfaces: input items, result items and register writes.
interface afg_in_if import afg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                op;
  logic [SAMPLE_W-1:0] sample_left;
  logic [SAMPLE_W-1:0] sample_right;
  logic                quantum_start;

  modport source (output valid, op, sample_left, sample_right, quantum_start, input ready);
  modport sink   (input valid, op, sample_left, sample_right, quantum_start, output ready);
endinterface

interface afg_out_if import afg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] out_left;
  logic [SAMPLE_W-1:0] out_right;
  logic                accepted;
  logic                from_queue;
  logic [FREE_W-1:0]   free_frames;

  modport source (output valid, out_left, out_right, accepted, from_queue, free_frames,
                  input ready);
  modport sink   (input valid, out_left, out_right, accepted, from_queue, free_frames,
                  output ready);
endinterface

interface afg_cfg_if import afg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/afg_front.sv
// Front end: accepts input beats, decodes and masks them into a short command queue.
module afg_front import afg_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  afg_in_if.sink    in_i,
  output head_t     head_o,
  input  logic      pop_i
);

  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
    SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  cmd_t           entry_q [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0] cnt_q;
  logic           push;
  cmd_t           cmd_in;

  assign in_i.ready = (cnt_q != QCW'(QUEUE_DEPTH));
  assign push       = in_i.valid && in_i.ready;

  always_comb begin
    cmd_in.op     = in_i.op ? OP_PULL : OP_PUSH;
    cmd_in.left   = in_i.sample_left & SAMPLE_MASK;
    cmd_in.right  = in_i.sample_right & SAMPLE_MASK;
    cmd_in.qstart = in_i.quantum_start;
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = entry_q[rd_ptr_q];

  function automatic logic [QPW-1:0] bump(input logic [QPW-1:0] p);
    return (p == QPW'(QUEUE_DEPTH - 1)) ? '0 : p + QPW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= bump(wr_ptr_q);
      if (pop_i) rd_ptr_q <= bump(rd_ptr_q);
      if (push && !pop_i) begin
        cnt_q <= cnt_q + QCW'(1);
      end else if (pop_i && !push) begin
        cnt_q <= cnt_q - QCW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/afg_back.sv
// Back end: frame memory, queue pointers, prefill gate and the result register.
module afg_back import afg_pkg::*; #(
  parameter int FIFO_FRAMES  = FIFO_FRAMES_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  head_t      head_i,
  output logic       pop_o,
  afg_out_if.source  out_o
);

  localparam int AW = $clog2(FIFO_FRAMES);
  localparam int CW = $clog2(FIFO_FRAMES + 1);
  localparam int NW = (CW > PREFILL_W) ? CW : PREFILL_W;
  localparam int FW = (CW > FREE_W) ? CW : FREE_W;
  localparam int MW = MAX_CHANNELS * SAMPLE_BITS;

  logic [MW-1:0] mem_q [FIFO_FRAMES];
  logic [MW-1:0] rd_data_q;

  logic [AW-1:0] wr_slot_q, rd_slot_q, wr_slot_d, rd_slot_d;
  logic [CW-1:0] count_q, count_d;
  logic          priming_q, priming_d;
  logic          playing_q, playing_d;

  logic              out_valid_q, out_acc_q, out_fromq_q, out_stereo_q;
  logic [FREE_W-1:0] out_free_q;
  logic              acc_d, fromq_d;

  logic          exec, wr_en, rd_en, stereo;
  logic [NW-1:0] need, prefill_ext, cap, count_ext;
  logic [CW-1:0] free_cw;
  logic [FW-1:0] free_ext;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] s);
    return (s == AW'(FIFO_FRAMES - 1)) ? '0 : s + AW'(1);
  endfunction

  assign exec  = head_i.valid && (!out_valid_q || out_o.ready);
  assign pop_o = exec;

  assign stereo      = (MAX_CHANNELS >= 2) && (cfg_i.channels >= CHAN_STEREO);
  assign prefill_ext = NW'(cfg_i.prefill);
  assign cap         = NW'(FIFO_FRAMES / 2);
  assign need        = (prefill_ext > cap) ? cap : prefill_ext;
  assign count_ext   = NW'(count_q);

  always_comb begin
    logic play;
    wr_slot_d = wr_slot_q;
    rd_slot_d = rd_slot_q;
    count_d   = count_q;
    priming_d = priming_q;
    playing_d = playing_q;
    acc_d     = 1'b0;
    fromq_d   = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    play      = playing_q;
    if (exec) begin
      unique case (head_i.cmd.op)
        OP_PUSH: begin
          if (count_q < CW'(FIFO_FRAMES)) begin
            wr_en     = 1'b1;
            wr_slot_d = bump(wr_slot_q);
            count_d   = count_q + CW'(1);
            acc_d     = 1'b1;
          end
        end
        OP_PULL: begin
          // quantum decision is taken on its first frame only
          if (head_i.cmd.qstart) begin
            if (!cfg_i.enable || (priming_q && (count_ext < need))) begin
              play = 1'b0;
            end else begin
              play      = 1'b1;
              priming_d = 1'b0;
            end
          end
          if (play) begin
            if (count_q == '0) begin
              play      = 1'b0;   // underrun: silence and regate
              priming_d = 1'b1;
            end else begin
              rd_en     = 1'b1;
              rd_slot_d = bump(rd_slot_q);
              count_d   = count_q - CW'(1);
              fromq_d   = 1'b1;
            end
          end
          playing_d = play;
        end
        default: ;
      endcase
    end
  end

  assign free_cw  = CW'(FIFO_FRAMES) - count_d;
  assign free_ext = FW'(free_cw);

  // frame memory: one write or one registered read per cycle while a command executes
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_slot_q] <= MW'({head_i.cmd.right[SAMPLE_BITS-1:0],
                               head_i.cmd.left[SAMPLE_BITS-1:0]});
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_slot_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_acc_q    <= acc_d;
      out_fromq_q  <= fromq_d;
      out_stereo_q <= stereo;
      out_free_q   <= free_ext[FREE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_slot_q   <= '0;
      rd_slot_q   <= '0;
      count_q     <= '0;
      priming_q   <= 1'b1;
      playing_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wr_slot_q <= wr_slot_d;
      rd_slot_q <= rd_slot_d;
      count_q   <= count_d;
      priming_q <= priming_d;
      playing_q <= playing_d;
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.accepted    = out_acc_q;
  assign out_o.from_queue  = out_fromq_q;
  assign out_o.free_frames = out_free_q;
  assign out_o.out_left    = out_fromq_q ? SAMPLE_W'(rd_data_q[SAMPLE_BITS-1:0]) : '0;
  assign out_o.out_right   = (out_fromq_q && out_stereo_q) ?
                             SAMPLE_W'(rd_data_q[MW-1 -: SAMPLE_BITS]) : '0;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(FIFO_FRAMES))
    else $error("frame count above queue depth");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> ($stable(count_q) && $stable(rd_slot_q)))
    else $error("queue state moved while result stalled");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_acc_q && out_fromq_q))
    else $error("result both stored and played a frame");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (count_q == $past(count_q) || count_q == $past(count_q) + CW'(1) ||
         count_q == $past(count_q) - CW'(1)))
    else $error("frame count jumped by more than one");
`endif

endmodule

>>> hw/rtl/audio_frame_fifo_prefill_gate.sv
// Top level: audio frame ring queue with prefill gate, config registers and submodules.
// A beat accepted into the two-entry command queue executes from the queue head; its
// result is registered and held in the result register while the output is stalled.
// Throughput: one push or pull beat per cycle unless the result stalls, set by the single
// frame memory port pair (one write or one registered read per beat) and the queue.
// Reset (rst_ni, async, active low) clears pointers, count, quantum state and registers;
// priming resets to one. The frame memory is not cleared and has no clearing pass.
module audio_frame_fifo_prefill_gate import afg_pkg::*; #(
  parameter int FIFO_FRAMES  = FIFO_FRAMES_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  afg_in_if.sink     in_i,
  afg_out_if.source  out_o,
  afg_cfg_if.sink    cfg_i
);

  // Configuration registers. The user must write them only while idle; the block
  // does not enforce it. Writes are always taken; an index beyond the list is dropped.
  cfg_t  cfg_q;
  head_t head;
  logic  pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable   <= 1'b0;
      cfg_q.channels <= CHAN_RST;
      cfg_q.prefill  <= PREFILL_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ENABLE:   cfg_q.enable   <= cfg_i.data[0];
        CFG_CHANNELS: cfg_q.channels <= cfg_i.data[CHAN_W-1:0];
        CFG_PREFILL:  cfg_q.prefill  <= cfg_i.data[PREFILL_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: takes input beats, masks samples, queues commands so the
  // producer side keeps moving while a result waits downstream.
  afg_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .head_o(head),
    .pop_i (pop)
  );

  // Back end: owns the frame memory and the gate; executes one command per
  // cycle whenever the result register is empty or being drained.
  afg_back #(
    .FIFO_FRAMES (FIFO_FRAMES),
    .MAX_CHANNELS(MAX_CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_q),
    .head_i(head),
    .pop_o (pop),
    .out_o (out_o)
  );

endmodule
